### hdl/prescaled_reload_timer_macros.svh
// ---------------------------------------------------------------------------
// Prescaled reload timer assertion macros
// Shared concurrent assertion shorthands for the timer block.
// ---------------------------------------------------------------------------
`ifndef PRESCALED_RELOAD_TIMER_MACROS_SVH
`define PRESCALED_RELOAD_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prescaled_reload_timer: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prescaled_reload_timer: assertion failed");

`endif

### hdl/prt_pkg.sv
// ---------------------------------------------------------------------------
// Prescaled reload timer package
// Widths, operation and register codes, and shared structs.
// ---------------------------------------------------------------------------
package prt_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int HALF_W        = 16;
    localparam int CMP_N         = 4;
    localparam int FLAG_W        = CMP_N + 1;
    localparam int KIND_W        = 3;
    localparam int SRV_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [HALF_W-1:0]        HALF_MASK  = 16'hFFFF;
    localparam logic [COUNTER_WIDTH-1:0] RELOAD_RST = COUNTER_WIDTH'(HALF_MASK);
    localparam logic [SRV_W-1:0]         SRV_NONE   = 3'd0;

    // Operation codes of an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_ACK    = 3'd4
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESCALE  = 3'd0,
        REG_RELOAD    = 3'd1,
        REG_ONE_PULSE = 3'd2,
        REG_UPD_IE    = 3'd3,
        REG_CMP_IE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [HALF_W-1:0] prescale_value;
        logic [HALF_W-1:0] reload_value;
        logic              one_pulse;
        logic              update_irq_enable;
        logic [CMP_N-1:0]  compare_irq_enable;
    } t_cfg;

    typedef struct packed {
        logic [HALF_W-1:0] count;
        logic              running;
        logic [FLAG_W-1:0] flags;
        logic              irq_pending;
        logic [SRV_W-1:0]  serviced;
        logic              callback_fire;
    } t_result;

endpackage

### hdl/prt_in_if.sv
// ---------------------------------------------------------------------------
// Timer input channel
// Valid/ready channel carrying one operation and its compare events.
// ---------------------------------------------------------------------------
interface prt_in_if;
    logic                        valid;
    logic                        ready;
    logic [prt_pkg::KIND_W-1:0]  kind;
    logic [prt_pkg::CMP_N-1:0]   compare_events;

    modport source (output valid, output kind, output compare_events, input ready);
    modport sink   (input valid, input kind, input compare_events, output ready);
endinterface

### hdl/prt_out_if.sv
// ---------------------------------------------------------------------------
// Timer result channel
// Valid/ready channel carrying the timer status after one item.
// ---------------------------------------------------------------------------
interface prt_out_if;
    logic                        valid;
    logic                        ready;
    logic [prt_pkg::HALF_W-1:0]  count;
    logic                        running;
    logic [prt_pkg::FLAG_W-1:0]  flags;
    logic                        irq_pending;
    logic [prt_pkg::SRV_W-1:0]   serviced;
    logic                        callback_fire;

    modport source (output valid, output count, output running, output flags,
                    output irq_pending, output serviced, output callback_fire,
                    input ready);
    modport sink   (input valid, input count, input running, input flags,
                    input irq_pending, input serviced, input callback_fire,
                    output ready);
endinterface

### hdl/prescaled_reload_timer.sv
// Pipeline: an accepted item is registered in the input register, processed by
// the core as it moves into the result register (two register stages).
// Throughput: one item per cycle; the input and result registers both advance
// whenever the result is taken or the result register is empty.
// Reset: synchronous, active low; clears counters, flags, mode and valids.
// ---------------------------------------------------------------------------
// Prescaled reload timer
// Prescaled 16-bit auto-reload up-counter with one-pulse mode and flags.
// ---------------------------------------------------------------------------
`include "prescaled_reload_timer_macros.svh"

module prescaled_reload_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    prt_in_if.sink                          i_item,
    prt_out_if.source                       o_res
);

    prt_pkg::t_cfg                 w_cfg;
    prt_pkg::t_result              w_res;
    prt_pkg::t_result              r_res;

    logic                          r_in_valid;
    logic [prt_pkg::KIND_W-1:0]    r_in_kind;
    logic [prt_pkg::CMP_N-1:0]     r_in_events;
    logic                          r_out_valid;
    logic                          w_adv;
    logic                          w_accept;

    prt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    prt_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_adv),
        .i_kind           (r_in_kind),
        .i_compare_events (r_in_events),
        .i_cfg            (w_cfg),
        .o_res            (w_res)
    );

    // Pipeline handshake: advance when the result slot is free or drains
    assign w_adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_accept     = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the input transfer and the computed result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind   <= i_item.kind;
            r_in_events <= i_item.compare_events;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.count         = r_res.count;
    assign o_res.running       = r_res.running;
    assign o_res.flags         = r_res.flags;
    assign o_res.irq_pending   = r_res.irq_pending;
    assign o_res.serviced      = r_res.serviced;
    assign o_res.callback_fire = r_res.callback_fire;

    // A processed item always lands in the result register
    `PRT_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    // Only an acknowledge reports a serviced flag
    `PRT_ASSERT_NEXT(a_srv_only_ack, i_clk, i_rst_n, w_adv && (r_in_kind != prt_pkg::KIND_ACK), (r_res.serviced == prt_pkg::SRV_NONE) && !r_res.callback_fire)
    // Stop leaves the counter cleared and halted
    `PRT_ASSERT_NEXT(a_stop_halts, i_clk, i_rst_n, w_adv && (r_in_kind == prt_pkg::KIND_STOP), !r_res.running && (r_res.count == '0) && !r_res.flags[0])
    // Interrupt request matches the pending flags under the current enables
    `PRT_ASSERT_IMPL(a_irq_match, i_clk, i_rst_n, r_out_valid, r_res.irq_pending == (|(r_res.flags & {w_cfg.compare_irq_enable, w_cfg.update_irq_enable})))

endmodule

### hdl/prt_cfg.sv
// ---------------------------------------------------------------------------
// Timer configuration registers
// Write-only register file for prescaler, reload, mode and interrupt enables.
// ---------------------------------------------------------------------------
module prt_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output prt_pkg::t_cfg                   o_cfg
);

    prt_pkg::t_cfg r_cfg;

    // Decode the index and update one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_value     <= '0;
            r_cfg.reload_value       <= prt_pkg::HALF_MASK;
            r_cfg.one_pulse          <= 1'b0;
            r_cfg.update_irq_enable  <= 1'b1;
            r_cfg.compare_irq_enable <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prt_pkg::REG_PRESCALE: begin
                    r_cfg.prescale_value <= i_cfg_wdata[prt_pkg::HALF_W-1:0];
                end
                prt_pkg::REG_RELOAD: begin
                    r_cfg.reload_value <= i_cfg_wdata[prt_pkg::HALF_W-1:0];
                end
                prt_pkg::REG_ONE_PULSE: begin
                    r_cfg.one_pulse <= i_cfg_wdata[0];
                end
                prt_pkg::REG_UPD_IE: begin
                    r_cfg.update_irq_enable <= i_cfg_wdata[0];
                end
                prt_pkg::REG_CMP_IE: begin
                    r_cfg.compare_irq_enable <= i_cfg_wdata[prt_pkg::CMP_N-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/prt_core.sv
// ---------------------------------------------------------------------------
// Timer core
// Counter state and the single-pass next-state and status logic per item.
// ---------------------------------------------------------------------------
module prt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [prt_pkg::KIND_W-1:0]    i_kind,
    input  logic [prt_pkg::CMP_N-1:0]     i_compare_events,
    input  prt_pkg::t_cfg                 i_cfg,
    output prt_pkg::t_result              o_res
);

    logic [prt_pkg::HALF_W-1:0]        r_pre_cnt, n_pre_cnt;
    logic [prt_pkg::COUNTER_WIDTH-1:0] r_main, n_main;
    logic                              r_en, n_en;
    logic [prt_pkg::FLAG_W-1:0]        r_flags, n_flags;
    logic [prt_pkg::HALF_W-1:0]        r_act_pre, n_act_pre;
    logic [prt_pkg::COUNTER_WIDTH-1:0] r_act_rel, n_act_rel;

    logic [prt_pkg::FLAG_W-1:0]        w_mask;
    logic [prt_pkg::FLAG_W-1:0]        w_hit;
    logic [prt_pkg::FLAG_W-1:0]        w_clr;
    logic [prt_pkg::SRV_W-1:0]         w_srv;

    assign w_mask = {i_cfg.compare_irq_enable, i_cfg.update_irq_enable};
    assign w_hit  = r_flags & w_mask;

    // Pick the lowest enabled pending flag for an acknowledge
    always_comb begin
        w_clr = '0;
        w_srv = prt_pkg::SRV_NONE;
        for (int i = prt_pkg::FLAG_W - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_clr    = '0;
                w_clr[i] = 1'b1;
                w_srv    = prt_pkg::SRV_W'(i + 1);
            end
        end
    end

    // Next state for the item
    always_comb begin
        n_pre_cnt = r_pre_cnt;
        n_main    = r_main;
        n_en      = r_en;
        n_flags   = r_flags;
        n_act_pre = r_act_pre;
        n_act_rel = r_act_rel;
        unique case (i_kind)
            prt_pkg::KIND_TICK: begin
                if (r_en) begin
                    if (r_pre_cnt != r_act_pre) begin
                        n_pre_cnt = r_pre_cnt + 1'b1;
                    end else begin
                        n_pre_cnt = '0;
                        if (r_act_rel != '0) begin
                            if (r_main == r_act_rel) begin
                                // rollover: flag, reload active values, stop in one-pulse mode
                                n_main     = '0;
                                n_flags[0] = 1'b1;
                                n_act_pre  = i_cfg.prescale_value;
                                n_act_rel  = prt_pkg::COUNTER_WIDTH'(i_cfg.reload_value);
                                if (i_cfg.one_pulse) begin
                                    n_en = 1'b0;
                                end
                            end else begin
                                n_main = r_main + 1'b1;
                            end
                        end
                    end
                end
            end
            prt_pkg::KIND_START: begin
                n_act_pre = i_cfg.prescale_value;
                n_act_rel = prt_pkg::COUNTER_WIDTH'(i_cfg.reload_value);
                n_pre_cnt = '0;
                n_main    = '0;
                n_en      = 1'b1;
            end
            prt_pkg::KIND_STOP: begin
                n_en       = 1'b0;
                n_main     = '0;
                n_flags[0] = 1'b0;
            end
            prt_pkg::KIND_UPDATE: begin
                n_act_pre = i_cfg.prescale_value;
                n_act_rel = prt_pkg::COUNTER_WIDTH'(i_cfg.reload_value);
                n_pre_cnt = '0;
                n_main    = '0;
            end
            prt_pkg::KIND_ACK: begin
                n_flags = r_flags & ~w_clr;
            end
            default: begin
            end
        endcase
        // latch compare events after the operation
        n_flags = n_flags | {i_compare_events, 1'b0};
    end

    // Status seen after the item
    always_comb begin
        o_res.count         = prt_pkg::HALF_W'(n_main);
        o_res.running       = n_en;
        o_res.flags         = n_flags;
        o_res.irq_pending   = |(n_flags & w_mask);
        o_res.serviced      = (i_kind == prt_pkg::KIND_ACK) ? w_srv : prt_pkg::SRV_NONE;
        o_res.callback_fire = (i_kind == prt_pkg::KIND_ACK) && (w_srv != prt_pkg::SRV_NONE);
    end

    // Hold state, advance on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cnt <= '0;
            r_main    <= '0;
            r_en      <= 1'b0;
            r_flags   <= '0;
            r_act_pre <= '0;
            r_act_rel <= prt_pkg::RELOAD_RST;
        end else if (i_step) begin
            r_pre_cnt <= n_pre_cnt;
            r_main    <= n_main;
            r_en      <= n_en;
            r_flags   <= n_flags;
            r_act_pre <= n_act_pre;
            r_act_rel <= n_act_rel;
        end
    end

endmodule

### sim/tb_prescaled_reload_timer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Prescaled reload timer testbench
// Drives timer operations and compare events through the input channel,
// predicts the status after each operation with a behavioral timer model,
// and compares every result transfer field by field. Both channels idle in
// random bursts, the receiver holds off for long stretches, and the timer
// settings change between phases.
// ---------------------------------------------------------------------------
module tb_prescaled_reload_timer;
    import prt_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int RST_CYCLES = 4;
    localparam int LONG_HOLD  = 64;
    localparam int RUN_LEN    = 150;
    localparam int RUN_PHASES = 13;
    localparam int SETTLE     = 8;
    localparam int CYCLE_CAP  = 500000;
    localparam int PRINT_CAP  = 40;

    // Codes outside the defined operations: the timer ignores them
    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CMP_N-1:0]  events;
    } t_op;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    prt_in_if  item_if ();
    prt_out_if res_if ();

    prescaled_reload_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_res       (res_if)
    );

    // Timer model state and its copy of the settings
    t_cfg                     cfg;
    logic [HALF_W-1:0]        pre_cnt;
    logic [COUNTER_WIDTH-1:0] main_cnt;
    logic                     run_en;
    logic [FLAG_W-1:0]        flag_q;
    logic [HALF_W-1:0]        act_prescale;
    logic [COUNTER_WIDTH-1:0] act_reload;

    t_op     op_queue[$];
    t_result status_expect[$];

    int  errors;
    int  results_seen;
    int  cycle_cnt;
    bit  bursts_on;
    bit  in_xfer;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    int  hold_requests;
    int  holds_started;

    always #CLK_HALF i_clk = ~i_clk;

    // Copy the programmed divider and reload into the active registers
    function automatic void load_active();
        act_prescale = cfg.prescale_value;
        act_reload   = COUNTER_WIDTH'(cfg.reload_value);
    endfunction

    // Apply one operation to the timer model and return the status it leaves
    function automatic t_result advance_timer(input logic [KIND_W-1:0] kind,
                                              input logic [CMP_N-1:0] events);
        logic [FLAG_W-1:0] en_mask;
        t_result           st;
        bit                done;
        en_mask  = {cfg.compare_irq_enable, cfg.update_irq_enable};
        st       = '0;
        done     = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (run_en) begin
                    if (pre_cnt != act_prescale) begin
                        pre_cnt = pre_cnt + 1'b1;
                    end else begin
                        pre_cnt = '0;
                        // zero reload blocks the main counter
                        if (act_reload != '0) begin
                            if (main_cnt == act_reload) begin
                                main_cnt  = '0;
                                flag_q[0] = 1'b1;
                                load_active();
                                if (cfg.one_pulse) run_en = 1'b0;
                            end else begin
                                main_cnt = main_cnt + 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_START: begin
                load_active();
                pre_cnt  = '0;
                main_cnt = '0;
                run_en   = 1'b1;
            end
            KIND_STOP: begin
                run_en    = 1'b0;
                main_cnt  = '0;
                flag_q[0] = 1'b0;
            end
            KIND_UPDATE: begin
                load_active();
                pre_cnt  = '0;
                main_cnt = '0;
            end
            KIND_ACK: begin
                // clear the first enabled pending flag, update first
                for (int n = 0; n < FLAG_W; n++) begin
                    if (!done && flag_q[n] && en_mask[n]) begin
                        flag_q[n]   = 1'b0;
                        st.serviced = SRV_W'(n + 1);
                        done        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // compare events latch after the operation
        flag_q = flag_q | {events, 1'b0};
        st.count         = HALF_W'(main_cnt);
        st.running       = run_en;
        st.flags         = flag_q;
        st.irq_pending   = |(flag_q & en_mask);
        st.callback_fire = (st.serviced != SRV_NONE);
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic void push_op(input logic [KIND_W-1:0] kind,
                                    input logic [CMP_N-1:0] events);
        t_op op;
        op.kind   = kind;
        op.events = events;
        op_queue.push_back(op);
    endfunction

    // Queue a run that starts the timer and then mostly ticks, with noise mixed in
    function automatic void queue_run(input int len);
        int               pick;
        logic [KIND_W-1:0] kind;
        logic [CMP_N-1:0]  events;
        push_op(KIND_START, '0);
        for (int n = 1; n < len; n++) begin
            pick   = $urandom_range(0, 99);
            events = ($urandom_range(0, 3) == 0) ? CMP_N'($urandom) : '0;
            if (pick < 65)      kind = KIND_TICK;
            else if (pick < 75) kind = KIND_ACK;
            else if (pick < 79) kind = KIND_UPDATE;
            else if (pick < 83) kind = KIND_START;
            else if (pick < 86) kind = KIND_STOP;
            else if (pick < 89) kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
            else                kind = KIND_W'($urandom);
            push_op(kind, events);
        end
    endfunction

    // Write one register; the model takes the value at the same time
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        case (idx)
            REG_PRESCALE:  cfg.prescale_value     = data;
            REG_RELOAD:    cfg.reload_value       = data;
            REG_ONE_PULSE: cfg.one_pulse          = data[0];
            REG_UPD_IE:    cfg.update_irq_enable  = data[0];
            REG_CMP_IE:    cfg.compare_irq_enable = data[CMP_N-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [HALF_W-1:0] prescale,
                              input logic [HALF_W-1:0] reload,
                              input logic one_pulse, input logic upd_ie,
                              input logic [CMP_N-1:0] cmp_ie);
        write_reg(REG_PRESCALE, prescale);
        write_reg(REG_RELOAD, reload);
        write_reg(REG_ONE_PULSE, CFG_DATA_W'(one_pulse));
        write_reg(REG_UPD_IE, CFG_DATA_W'(upd_ie));
        write_reg(REG_CMP_IE, CFG_DATA_W'(cmp_ie));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold until every queued operation is transferred and every status has come
    task automatic wait_idle();
        while (op_queue.size() != 0 || item_if.valid || status_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Sample both channels: predict on input transfers, check result transfers
    always @(posedge i_clk) begin
        t_result want;
        in_xfer <= i_rst_n && item_if.valid && item_if.ready;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready)
                status_expect.push_back(advance_timer(item_if.kind, item_if.compare_events));
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (status_expect.size() == 0) begin
                    report_mismatch("result with no expectation waiting");
                end else begin
                    want = status_expect.pop_front();
                    check_field("count", res_if.count, want.count);
                    check_field("running", res_if.running, want.running);
                    check_field("flags", res_if.flags, want.flags);
                    check_field("irq_pending", res_if.irq_pending, want.irq_pending);
                    check_field("serviced", res_if.serviced, want.serviced);
                    check_field("callback_fire", res_if.callback_fire, want.callback_fire);
                end
            end
        end
    end

    // Input driver: offer the next queued operation once the last one is taken
    always @(negedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || in_xfer) begin
            if (send_gap > 0) begin
                send_gap--;
                item_if.valid <= 1'b0;
            end else if (op_queue.size() != 0) begin
                op = op_queue.pop_front();
                item_if.kind           <= op.kind;
                item_if.compare_events <= op.events;
                item_if.valid          <= 1'b1;
                if (bursts_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold-offs on request, short random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = LONG_HOLD - 1;
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Drop the run if it stalls
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [HALF_W-1:0] prescale;
        logic [HALF_W-1:0] reload;
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = REG_PRESCALE;
        i_cfg_wdata            = '0;
        item_if.valid          = 1'b0;
        item_if.kind           = KIND_TICK;
        item_if.compare_events = '0;
        res_if.ready           = 1'b0;
        errors        = 0;
        results_seen  = 0;
        cycle_cnt     = 0;
        bursts_on     = 1'b1;
        in_xfer       = 1'b0;
        send_gap      = 0;
        stall_left    = 0;
        hold_left     = 0;
        hold_requests = 0;
        holds_started = 0;

        // model state after reset
        cfg.prescale_value     = '0;
        cfg.reload_value       = HALF_MASK;
        cfg.one_pulse          = 1'b0;
        cfg.update_irq_enable  = 1'b1;
        cfg.compare_irq_enable = '0;
        pre_cnt      = '0;
        main_cnt     = '0;
        run_en       = 1'b0;
        flag_q       = '0;
        act_prescale = '0;
        act_reload   = RELOAD_RST;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, every operation, restart, ignored codes
        push_op(KIND_TICK, '0);             // tick while stopped
        push_op(KIND_ACK, '0);              // acknowledge with nothing pending
        push_op(KIND_START, '0);
        push_op(KIND_TICK, '0);
        push_op(KIND_TICK, 4'b0001);
        push_op(KIND_START, '0);            // restart while running
        push_op(KIND_TICK, 4'b0010);
        push_op(KIND_UPDATE, 4'b1000);      // clears counters, keeps running
        push_op(KIND_ACK, 4'b1111);         // compare flags not enabled
        push_op(KIND_RSVD_LO, '0);
        push_op(KIND_RSVD_HI, 4'b0100);
        push_op(KIND_STOP, '0);
        wait_idle();

        // Directed: one-pulse rollover, then acknowledge order
        set_config(16'd1, 16'd2, 1'b1, 1'b1, 4'b1111);
        push_op(KIND_START, '0);
        repeat (7) push_op(KIND_TICK, '0);  // last tick lands after expiry
        push_op(KIND_ACK, 4'b1111);         // clears update, not same-item events
        push_op(KIND_ACK, '0);
        wait_idle();

        // Directed: zero reload blocks the main counter
        set_config(16'd0, 16'd0, 1'b0, 1'b0, 4'b0000);
        push_op(KIND_START, '0);
        push_op(KIND_TICK, '0);
        push_op(KIND_TICK, '0);
        push_op(KIND_ACK, '0);
        wait_idle();

        // Random runs, settings changed only while no operation is in flight
        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            if (ph == 0) begin
                set_config(HALF_MASK, HALF_MASK, 1'b0, 1'b1, 4'b1111);
            end else if (ph == 1) begin
                set_config(16'd0, 16'd1, 1'b0, 1'b1, CMP_N'($urandom));
            end else begin
                prescale = ($urandom_range(0, 3) == 0) ? HALF_W'($urandom)
                                                       : HALF_W'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       reload = '0;
                    1:       reload = HALF_MASK;
                    default: reload = HALF_W'($urandom_range(1, 12));
                endcase
                set_config(prescale, reload, 1'($urandom), 1'($urandom), CMP_N'($urandom));
            end
            bursts_on = (ph < RUN_PHASES - 3) && (ph % 3 != 2);
            if (ph == 3 || ph == 7) hold_requests++;
            queue_run(RUN_LEN);
            wait_idle();
        end

        if (status_expect.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      status_expect.size()));
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
